// ===== rtl/clnw_pkg.sv =====
// ----------------------------------------------------------------------------
// clnw_pkg: shared types and constants of the character LCD nibble writer
// Holds the request, job and step types, the function and extra-wait codes,
// the register indexes and reset values, and the init command table.
// ----------------------------------------------------------------------------
package clnw_pkg;

	// request kinds
	localparam logic [2:0] FUNC_DATA   = 3'd0;
	localparam logic [2:0] FUNC_CMD    = 3'd1;
	localparam logic [2:0] FUNC_CURSOR = 3'd2;
	localparam logic [2:0] FUNC_CLEAR  = 3'd3;
	localparam logic [2:0] FUNC_INIT   = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_PULSE  = 2'd0;
	localparam logic [1:0] REG_SETTLE = 2'd1;
	localparam logic [1:0] REG_SLOW   = 2'd2;
	localparam logic [1:0] REG_POWER  = 2'd3;

	localparam logic [15:0] PULSE_RESET  = 16'd20;
	localparam logic [15:0] SETTLE_RESET = 16'd100;
	localparam logic [15:0] SLOW_RESET   = 16'd5000;
	localparam logic [15:0] POWER_RESET  = 16'd50000;

	// extra wait added to the final step of a byte
	localparam logic [1:0] EXTRA_NONE   = 2'd0;
	localparam logic [1:0] EXTRA_SETTLE = 2'd1;
	localparam logic [1:0] EXTRA_SLOW   = 2'd2;

	// LCD command bytes
	localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
	localparam logic [7:0] LCD_SET_DDR       = 8'h80;
	localparam logic [7:0] ROW1_OFFSET       = 8'h40;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int unsigned INIT_LEN = 7;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] byte_value;
		logic [1:0] row;
		logic [4:0] column;
	} req_t;

	typedef struct packed {
		logic       reg_select;
		logic [3:0] nibble;
		logic       enable;
		logic [15:0] hold_us;
		logic       last;
	} step_t;

	// one classified request waiting for the back end
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] data;
		logic [1:0] extra;
	} job_t;

	typedef struct packed {
		logic [15:0] pulse_us;
		logic [15:0] cmd_settle_us;
		logic [15:0] slow_cmd_us;
		logic [15:0] power_up_us;
	} cfg_t;

	// power-up init sequence for 4-bit mode, two lines
	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h33;
			3'd1: c = 8'h32;
			3'd2: c = 8'h28;
			3'd3: c = 8'h08;
			3'd4: c = 8'h01;
			3'd5: c = 8'h06;
			3'd6: c = 8'h0C;
			default: c = 8'h0F;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/clnw_front.sv =====
// ----------------------------------------------------------------------------
// clnw_front: request decode
// Accepts requests, turns each into a job (byte, RS level, extra wait) and
// pushes it into the job queue. Bad cursor positions and unknown kinds are
// accepted and dropped.
// ----------------------------------------------------------------------------
module clnw_front #(
	parameter int LINE_LENGTH = 16
) (
	input  logic            req_valid,
	input  clnw_pkg::req_t  req,
	output logic            req_stall,
	input  logic            q_full,
	output logic            q_push,
	output clnw_pkg::job_t  job
);
	import clnw_pkg::*;

	logic keep;
	logic cursor_ok;

	assign cursor_ok = (req.row[1] == 1'b0) && (32'(req.column) < 32'(LINE_LENGTH));

	// classify the request
	always_comb begin
		job  = '0;
		keep = 1'b1;
		unique case (req.func)
			FUNC_DATA: begin
				job.rs    = 1'b1;
				job.data  = req.byte_value;
				job.extra = EXTRA_NONE;
			end
			FUNC_CMD: begin
				job.data  = req.byte_value;
				job.extra = EXTRA_SETTLE;
			end
			FUNC_CURSOR: begin
				// column is below 32, so the row offset only sets bit 6
				job.data  = LCD_SET_DDR | (req.row[0] ? ROW1_OFFSET : 8'h00) | 8'(req.column);
				job.extra = EXTRA_SETTLE;
				keep      = cursor_ok;
			end
			FUNC_CLEAR: begin
				job.data  = CMD_CLEAR_DISPLAY;
				job.extra = EXTRA_SLOW;
			end
			FUNC_INIT: begin
				job.is_init = 1'b1;
				job.extra   = EXTRA_SLOW;
			end
			default: keep = 1'b0;
		endcase
	end

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full && keep;

endmodule

// ===== rtl/clnw_queue.sv =====
// ----------------------------------------------------------------------------
// clnw_queue: job queue
// Small register FIFO between decode and the step sequencer.
// ----------------------------------------------------------------------------
module clnw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clnw_pkg::job_t wr_job,
	input  logic           pop,
	output clnw_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);
	import clnw_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full   = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill level; depth is a power of two so pointers wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/clnw_back.sv =====
// ----------------------------------------------------------------------------
// clnw_back: step sequencer
// Expands the job at the queue head into pin steps in an output register, one
// per cycle unless step_stall holds it. Pops the job when its final step is loaded.
// ----------------------------------------------------------------------------
module clnw_back (
	input  logic            clk,
	input  logic            arst_n,
	input  clnw_pkg::cfg_t  cfg,
	input  clnw_pkg::job_t  job,
	input  logic            job_valid,
	output logic            pop,
	output logic            step_valid,
	output clnw_pkg::step_t step,
	input  logic            step_stall
);
	import clnw_pkg::*;

	logic [4:0]  cnt_q;
	logic        step_valid_q;
	step_t       step_q;

	logic        load;
	logic [4:0]  pos;
	logic [4:0]  k;
	logic [2:0]  cmd_idx;
	logic [1:0]  phase;
	logic        idle_step;
	logic        is_last;
	logic [7:0]  cur_byte;
	logic [15:0] extra_a;
	logic [15:0] extra_b;
	logic [17:0] sum;
	step_t       nxt;

	// position in the step list; byte jobs skip the idle step
	assign pos       = job.is_init ? cnt_q : cnt_q + 5'd1;
	assign k         = pos - 5'd1;
	assign cmd_idx   = k[4:2];
	assign phase     = k[1:0];
	assign idle_step = (pos == 5'd0);
	assign is_last   = !idle_step && (phase == 2'd3) &&
		(!job.is_init || cmd_idx == 3'(INIT_LEN - 1));
	assign cur_byte  = job.is_init ? init_cmd(cmd_idx) : job.data;

	assign load = job_valid && (!step_valid_q || !step_stall);
	assign pop  = load && is_last;

	// extra wait on the final step of a byte
	always_comb begin
		extra_a = '0;
		extra_b = '0;
		if (phase == 2'd3) begin
			unique case (job.extra)
				EXTRA_SETTLE: extra_a = cfg.cmd_settle_us;
				EXTRA_SLOW: begin
					extra_a = cfg.cmd_settle_us;
					extra_b = cfg.slow_cmd_us;
				end
				default: ;
			endcase
		end
	end

	assign sum = 18'(cfg.pulse_us) + 18'(extra_a) + 18'(extra_b);

	// build the next step
	always_comb begin
		nxt = '0;
		if (idle_step) begin
			nxt.hold_us = cfg.power_up_us;
		end else begin
			nxt.reg_select = job.rs;
			nxt.nibble     = phase[1] ? cur_byte[3:0] : cur_byte[7:4];
			nxt.enable     = !phase[0];
			nxt.hold_us    = (|sum[17:16]) ? 16'hFFFF : sum[15:0];
			nxt.last       = is_last;
		end
	end

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			step_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= is_last ? 5'd0 : cnt_q + 5'd1;
			end
			if (load) begin
				step_valid_q <= 1'b1;
			end else if (!step_stall) begin
				step_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			step_q <= nxt;
		end
	end

	assign step_valid = step_valid_q;
	assign step       = step_q;

endmodule

// ===== rtl/char_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer: 4-bit character LCD pin-step generator
// Expands data, command, cursor, clear and init requests into timed pin steps
// (RS, D7..D4, EN, hold time) for a two-line character LCD.
// ----------------------------------------------------------------------------
//  port group   kind         handshake            payload
//  req          request in   req_valid/req_stall  req (req_t)
//  step         step out     step_valid/step_stall step (step_t)
//  cfg          reg write    cfg_wen              cfg_index, cfg_data
//
//  One step leaves per cycle unless step_stall holds it; the step sequencer is
//  the limit. Requests queue two deep behind it.
//  A request's first step is registered in the job queue, then the output register.
//  Dropped requests (bad cursor, unknown kind) are accepted and give nothing.
//  arst_n clears the queue, sequencer and registers to their reset values.
//  step_stall freezes the output register; decode keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer #(
	parameter int LINE_LENGTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  clnw_pkg::req_t  req,
	output logic            step_valid,
	input  logic            step_stall,
	output clnw_pkg::step_t step,
	input  logic            cfg_wen,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	import clnw_pkg::*;

	cfg_t cfg_q;
	job_t push_job;
	job_t head_job;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_us      <= PULSE_RESET;
			cfg_q.cmd_settle_us <= SETTLE_RESET;
			cfg_q.slow_cmd_us   <= SLOW_RESET;
			cfg_q.power_up_us   <= POWER_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_PULSE:  cfg_q.pulse_us      <= cfg_data;
				REG_SETTLE: cfg_q.cmd_settle_us <= cfg_data;
				REG_SLOW:   cfg_q.slow_cmd_us   <= cfg_data;
				REG_POWER:  cfg_q.power_up_us   <= cfg_data;
				default: ;
			endcase
		end
	end

	clnw_front #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_front (
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.q_full    (q_full),
		.q_push    (q_push),
		.job       (push_job)
	);

	clnw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (push_job),
		.pop    (q_pop),
		.rd_job (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	clnw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.job        (head_job),
		.job_valid  (!q_empty),
		.pop        (q_pop),
		.step_valid (step_valid),
		.step       (step),
		.step_stall (step_stall)
	);

`ifndef SYNTHESIS
	// the sequencer only retires a job that is really queued
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job popped from empty queue");

	// a push never lands on a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");

	// the final step of a request always drops EN
	a_last_en_low: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step.last |-> !step.enable)
		else $error("final step with EN high");

	// a popped job leaves its final step valid in the output register
	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> step_valid && step.last)
		else $error("job retired without a final step");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the character LCD nibble writer
// Sends directed and random LCD requests under several register settings. An
// in-bench model expands each accepted request into the pin steps it should
// give. Every step transfer is compared with the oldest of those steps.
// Random idling is applied on the request side and the step side.
// ----------------------------------------------------------------------------
module tb_top;
	import clnw_pkg::*;

	localparam int LINE_LEN       = 16;
	localparam int RANDOM_ITEMS   = 300;
	localparam int PHASES         = 5;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	// request kinds the block drops
	localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
	localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
	localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;

	// expected pin steps of every accepted request, oldest first
	class lcd_step_board;
		logic [15:0] pulse;
		logic [15:0] settle;
		logic [15:0] slow;
		logic [15:0] power_up;
		logic [7:0]  init_seq [7];
		step_t       due [$];
		int unsigned errors;

		function new();
			pulse    = PULSE_RESET;
			settle   = SETTLE_RESET;
			slow     = SLOW_RESET;
			power_up = POWER_RESET;
			init_seq = '{8'h33, 8'h32, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
			errors   = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_PULSE:  pulse = val;
				REG_SETTLE: settle = val;
				REG_SLOW:   slow = val;
				REG_POWER:  power_up = val;
				default: ;
			endcase
		endfunction

		function void push_step(logic rs, logic [3:0] nib, logic en, int unsigned hold,
				logic fin);
			step_t s;
			s.reg_select = rs;
			s.nibble     = nib;
			s.enable     = en;
			s.hold_us    = (hold > 32'd65535) ? 16'hFFFF : hold[15:0];
			s.last       = fin;
			due.push_back(s);
		endfunction

		// high nibble then low nibble, each as EN high then EN low
		function void push_byte(logic rs, logic [7:0] b, int unsigned extra, logic fin);
			push_step(rs, b[7:4], 1'b1, 32'(pulse), 1'b0);
			push_step(rs, b[7:4], 1'b0, 32'(pulse), 1'b0);
			push_step(rs, b[3:0], 1'b1, 32'(pulse), 1'b0);
			push_step(rs, b[3:0], 1'b0, 32'(pulse) + extra, fin);
		endfunction

		// returns how many steps the request gives
		function int add_request(req_t r);
			int          before_n;
			int unsigned slow_wait;
			logic [7:0]  addr;
			before_n  = due.size();
			slow_wait = 32'(settle) + 32'(slow);
			case (r.func)
				FUNC_DATA: push_byte(1'b1, r.byte_value, 0, 1'b1);
				FUNC_CMD:  push_byte(1'b0, r.byte_value, 32'(settle), 1'b1);
				FUNC_CURSOR: begin
					// off-screen positions are dropped
					if (r.row <= 2'd1 && r.column < LINE_LEN) begin
						addr = (r.row[0] ? ROW1_OFFSET : 8'h00) + 8'(r.column);
						push_byte(1'b0, LCD_SET_DDR | addr, 32'(settle), 1'b1);
					end
				end
				FUNC_CLEAR: push_byte(1'b0, CMD_CLEAR_DISPLAY, slow_wait, 1'b1);
				FUNC_INIT: begin
					// power-up idle step, then the init command bytes
					push_step(1'b0, 4'h0, 1'b0, 32'(power_up), 1'b0);
					for (int i = 0; i < 7; i++) begin
						push_byte(1'b0, init_seq[i], slow_wait, i == 6);
					end
				end
				default: ;
			endcase
			return due.size() - before_n;
		endfunction

		function void check_step(step_t got);
			step_t want;
			if (due.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected step: rs=%0d nib=%h en=%0d hold=%0d last=%0d",
						got.reg_select, got.nibble, got.enable, got.hold_us, got.last);
				return;
			end
			want = due.pop_front();
			if (got.reg_select !== want.reg_select || got.nibble !== want.nibble ||
					got.enable !== want.enable || got.hold_us !== want.hold_us ||
					got.last !== want.last) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("step mismatch: exp rs=%0d nib=%h en=%0d hold=%0d last=%0d, %s",
						want.reg_select, want.nibble, want.enable, want.hold_us,
						want.last, $sformatf("got rs=%0d nib=%h en=%0d hold=%0d last=%0d",
						got.reg_select, got.nibble, got.enable, got.hold_us, got.last));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        step_valid;
	logic        step_stall;
	step_t       step;
	logic        cfg_wen;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	lcd_step_board board;
	bit            gaps_on = 1'b1;
	int unsigned   quiet_cycles = 0;

	char_lcd_nibble_writer #(.LINE_LENGTH(LINE_LEN)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.step_valid (step_valid),
		.step_stall (step_stall),
		.step       (step),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// step-side stall bursts, never back to back
	initial begin
		step_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				step_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				step_stall <= 1'b0;
			end
		end
	end

	// check every step transfer
	always @(posedge clk) begin
		if (arst_n && step_valid && !step_stall)
			board.check_step(step);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (step_valid && !step_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic req_t make_req(logic [2:0] f, logic [7:0] b, logic [1:0] rw,
			logic [4:0] c);
		req_t r;
		r.func       = f;
		r.byte_value = b;
		r.row        = rw;
		r.column     = c;
		return r;
	endfunction

	// mostly well-formed requests, some off-screen cursors and unknown kinds
	function automatic req_t random_request();
		req_t r;
		int   pick;
		r = make_req(FUNC_DATA, 8'($urandom), 2'($urandom), 5'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			r.func = FUNC_DATA;
		end else if (pick < 50) begin
			r.func = FUNC_CMD;
		end else if (pick < 75) begin
			r.func = FUNC_CURSOR;
			if ($urandom_range(0, 4) != 0) begin
				r.row    = 2'($urandom_range(0, 1));
				r.column = 5'($urandom_range(0, LINE_LEN - 1));
			end
		end else if (pick < 83) begin
			r.func = FUNC_CLEAR;
		end else if (pick < 88) begin
			r.func = FUNC_INIT;
		end else begin
			r.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
		end
		return r;
	endfunction

	// one request transfer, with an optional gap in front of it
	task automatic send_request(input req_t r, output int made);
		int gap;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		forever begin
			@(posedge clk);
			if (!req_stall)
				break;
		end
		made = board.add_request(r);
	endtask

	// wait until every expected step has arrived and the block is quiet
	task automatic settle_down();
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic write_all(input logic [15:0] p, input logic [15:0] s,
			input logic [15:0] sl, input logic [15:0] pw);
		write_reg(REG_PULSE, p);
		write_reg(REG_SETTLE, s);
		write_reg(REG_SLOW, sl);
		write_reg(REG_POWER, pw);
	endtask

	initial begin
		req_t r;
		int   made;
		int   done;
		board     = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_wen   = 1'b0;
		cfg_index = REG_PULSE;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed requests at reset register values
		send_request(make_req(FUNC_DATA, 8'h00, 2'd0, 5'd0), made);
		send_request(make_req(FUNC_DATA, 8'hFF, 2'd3, 5'd31), made);
		send_request(make_req(FUNC_CMD, 8'h00, 2'd0, 5'd0), made);
		send_request(make_req(FUNC_CMD, 8'hFF, 2'd3, 5'd31), made);
		send_request(make_req(FUNC_CMD, 8'hA5, 2'd1, 5'd10), made);
		send_request(make_req(FUNC_CURSOR, 8'h00, 2'd0, 5'd0), made);
		send_request(make_req(FUNC_CURSOR, 8'hFF, 2'd1, 5'd15), made);
		send_request(make_req(FUNC_CURSOR, 8'h3C, 2'd1, 5'd0), made);
		send_request(make_req(FUNC_CURSOR, 8'h00, 2'd0, 5'd15), made);
		// off-screen cursors: bad row, bad column, both
		send_request(make_req(FUNC_CURSOR, 8'h00, 2'd2, 5'd3), made);
		send_request(make_req(FUNC_CURSOR, 8'h00, 2'd0, 5'd16), made);
		send_request(make_req(FUNC_CURSOR, 8'h00, 2'd1, 5'd31), made);
		send_request(make_req(FUNC_CURSOR, 8'h00, 2'd3, 5'd31), made);
		send_request(make_req(FUNC_CLEAR, 8'h77, 2'd2, 5'd9), made);
		send_request(make_req(FUNC_INIT, 8'h12, 2'd1, 5'd4), made);
		// unknown request kinds
		send_request(make_req(FUNC_SPARE_LO, 8'h41, 2'd0, 5'd0), made);
		send_request(make_req(FUNC_SPARE_MID, 8'h42, 2'd1, 5'd1), made);
		send_request(make_req(FUNC_SPARE_HI, 8'hFF, 2'd3, 5'd31), made);
		send_request(make_req(FUNC_DATA, 8'h5A, 2'd0, 5'd0), made);
		send_request(make_req(FUNC_CLEAR, 8'h00, 2'd0, 5'd0), made);
		settle_down();

		// random phases, each under its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_all(16'd0, 16'd0, 16'd0, 16'd0);
				1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: write_all(16'hFFFF, 16'd1, 16'd0, 16'd1);
				3: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				default: write_all(16'($urandom_range(1, 200)), 16'($urandom_range(0, 2000)),
					16'($urandom_range(0, 20000)), 16'($urandom_range(0, 65535)));
			endcase
			// no idling in the closing phase
			gaps_on = (phase != PHASES - 1);
			done = 0;
			while (done < RANDOM_ITEMS / PHASES) begin
				r = random_request();
				send_request(r, made);
				if (made != 0)
					done++;
			end
			settle_down();
		end

		if (board.errors == 0 && board.due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== char_lcd_nibble_writer.f =====
rtl/clnw_pkg.sv
rtl/clnw_front.sv
rtl/clnw_queue.sv
rtl/clnw_back.sv
rtl/char_lcd_nibble_writer.sv
test/tb_top.sv
